FILE: sv/u8u16om_pkg.sv
// ----------------------------------------------------------------------------
// u8u16om_pkg
// shared types and constants for the utf-8 to utf-16 offset map
// ----------------------------------------------------------------------------
package u8u16om_pkg;

  localparam int OUT_BITS = 16;
  localparam int VAL_BITS = 21;

  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_VAL   = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_VAL  = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_VAL  = 8'b1110_0000;
  localparam logic [7:0] ASCII_MASK = 8'b1000_0000;
  localparam logic [7:0] KEEP2_MASK = 8'b0001_1111;
  localparam logic [7:0] KEEP3_MASK = 8'b0000_1111;
  localparam logic [7:0] KEEP4_MASK = 8'b0000_0111;
  localparam logic [7:0] CONT_BITS  = 8'b0011_1111;

  localparam logic [VAL_BITS-1:0] CP_SUPP = 21'h10000;

  localparam logic [1:0] EXP_ONE   = 2'd1;
  localparam logic [1:0] EXP_TWO   = 2'd2;
  localparam logic [1:0] EXP_THREE = 2'd3;

  localparam logic [1:0] Q_DEPTH = 2'd2;

  typedef struct packed {
    logic [OUT_BITS-1:0] byte_offset;
    logic                final_entry;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: sv/utf8_to_utf16_offset_map.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_offset_map
// maps each utf-16 code unit of a zero-terminated utf-8 text to the byte
// offset where its character starts
//
// input channel: one text byte per transaction (in_valid / in_stall /
// in_text_byte); a zero byte ends the text. result channel: one entry per
// transaction (out_valid / out_stall / out_byte_offset / out_final_entry).
// each utf-16 unit gives one entry with the start offset of its character;
// the terminator gives a final entry, flagged, holding the text length.
// an accepted byte waits in the input register; its entries then go to
// the two-entry result queue, whose head drives the result port, moving
// one entry per cycle while out_stall is low. throughput: one byte per
// cycle while the queue has room; a two-entry byte waits for two slots.
// reset (rst_n low, synchronous) empties the input register and the queue
// and clears the decode state; after each terminator the decode state
// clears by itself. while out_stall is high the head entry holds and the
// input register keeps taking bytes until the queue has no room left.
// ----------------------------------------------------------------------------
module utf8_to_utf16_offset_map
  import u8u16om_pkg::*;
#(
  parameter int OFFSET_BITS = 16
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_text_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] out_byte_offset,
  output logic                out_final_entry
);

  push_t      push;
  logic [1:0] q_free;
  logic [1:0] q_cnt;

  u8u16om_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_text_byte(in_text_byte),
    .q_free      (q_free),
    .push        (push)
  );

  u8u16om_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .q_free         (q_free),
    .q_cnt          (q_cnt),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_offset(out_byte_offset),
    .out_final_entry(out_final_entry)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt != 2'd3)
    else $error("result queue overfilled");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.n <= q_free)
    else $error("push exceeds free queue slots");

  a_two_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |=> out_valid && q_cnt == 2'd2)
    else $error("double entry lost");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> push.n == 2'd0)
    else $error("input stalled while entries pushed");

endmodule

FILE: sv/u8u16om_outq.sv
// ----------------------------------------------------------------------------
// u8u16om_outq
// two-entry result queue, takes up to two entries per cycle, drives one
// ----------------------------------------------------------------------------
module u8u16om_outq
  import u8u16om_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  push_t               push,
  output logic [1:0]          q_free,
  output logic [1:0]          q_cnt,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] out_byte_offset,
  output logic                out_final_entry
);

  logic [1:0] cnt_r, cnt_nxt, cnt_ap;
  result_t    e0_r, e0_nxt, e1_r, e1_nxt;
  logic       pop;

  assign pop    = (cnt_r != 2'd0) && !out_stall;
  assign cnt_ap = cnt_r - {1'b0, pop};
  assign q_free = Q_DEPTH - cnt_ap;
  assign q_cnt  = cnt_r;

  always_comb begin
    cnt_nxt = cnt_ap + push.n;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    case (cnt_ap)
      2'd0: begin
        e0_nxt = push.r0;
        e1_nxt = push.r1;
      end
      2'd1: begin
        e0_nxt = pop ? e1_r : e0_r;
        e1_nxt = push.r0;
      end
      default: begin
        e0_nxt = e0_r;
        e1_nxt = e1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_byte_offset = e0_r.byte_offset;
  assign out_final_entry = e0_r.final_entry;

endmodule

FILE: sv/u8u16om_decode.sv
// ----------------------------------------------------------------------------
// u8u16om_decode
// input register, utf-8 decode state and per-byte result generation
// ----------------------------------------------------------------------------
module u8u16om_decode
  import u8u16om_pkg::*;
#(
  parameter int OFFSET_BITS = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic [1:0] q_free,
  output push_t      push
);

  logic                   in_v_r, in_v_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [1:0]             exp_r, exp_nxt;
  logic [VAL_BITS-1:0]    dv_r, dv_nxt;
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;

  logic [OFFSET_BITS+OUT_BITS-1:0] seen_ext, start_ext;
  logic [OUT_BITS-1:0]             seen16, start16;
  logic [OFFSET_BITS-1:0]          seen_inc;
  logic [VAL_BITS-1:0]             dv_cont;
  logic [1:0]                      exp_dec;
  logic                            is_cont;
  push_t                           res;
  logic                            proc;

  assign seen_ext  = {{OUT_BITS{1'b0}}, seen_r};
  assign start_ext = {{OUT_BITS{1'b0}}, start_r};
  assign seen16    = seen_ext[OUT_BITS-1:0];
  assign start16   = start_ext[OUT_BITS-1:0];
  assign seen_inc  = (&seen_r) ? seen_r : seen_r + 1'b1;
  assign dv_cont   = {dv_r[VAL_BITS-7:0], byte_r[5:0] & CONT_BITS[5:0]};
  assign exp_dec   = exp_r - 2'd1;
  assign is_cont   = pend_r && ((byte_r & CONT_MASK) == CONT_VAL);

  always_comb begin
    res       = '{n: 2'd0, r0: '{seen16, 1'b0}, r1: '{seen16, 1'b0}};
    pend_nxt  = pend_r;
    start_nxt = start_r;
    exp_nxt   = exp_r;
    dv_nxt    = dv_r;
    seen_nxt  = seen_r;
    if (byte_r == 8'd0) begin
      if (pend_r) begin
        res.n  = 2'd2;
        res.r0 = '{start16, 1'b0};
        res.r1 = '{seen16, 1'b1};
      end else begin
        res.n  = 2'd1;
        res.r0 = '{seen16, 1'b1};
      end
      pend_nxt  = 1'b0;
      start_nxt = '0;
      exp_nxt   = 2'd0;
      dv_nxt    = '0;
      seen_nxt  = '0;
    end else if (is_cont) begin
      dv_nxt   = dv_cont;
      exp_nxt  = exp_dec;
      seen_nxt = seen_inc;
      if (exp_dec == 2'd0) begin
        res.n    = (dv_cont >= CP_SUPP) ? 2'd2 : 2'd1;
        res.r0   = '{start16, 1'b0};
        res.r1   = '{start16, 1'b0};
        pend_nxt = 1'b0;
        dv_nxt   = '0;
      end
    end else begin
      res.n    = {1'b0, pend_r} + {1'b0, ((byte_r & ASCII_MASK) == 8'd0)};
      res.r0   = '{(pend_r ? start16 : seen16), 1'b0};
      res.r1   = '{seen16, 1'b0};
      seen_nxt = seen_inc;
      if ((byte_r & ASCII_MASK) == 8'd0) begin
        pend_nxt = 1'b0;
        exp_nxt  = 2'd0;
        dv_nxt   = '0;
      end else begin
        pend_nxt  = 1'b1;
        start_nxt = seen_r;
        if ((byte_r & LEAD2_MASK) == LEAD2_VAL) begin
          dv_nxt  = {{(VAL_BITS-8){1'b0}}, byte_r & KEEP2_MASK};
          exp_nxt = EXP_ONE;
        end else if ((byte_r & LEAD3_MASK) == LEAD3_VAL) begin
          dv_nxt  = {{(VAL_BITS-8){1'b0}}, byte_r & KEEP3_MASK};
          exp_nxt = EXP_TWO;
        end else begin
          dv_nxt  = {{(VAL_BITS-8){1'b0}}, byte_r & KEEP4_MASK};
          exp_nxt = EXP_THREE;
        end
      end
    end
  end

  assign proc     = in_v_r && (res.n <= q_free);
  assign in_stall = in_v_r && !proc;
  assign in_v_nxt = (in_valid && !in_stall) ? 1'b1 : (proc ? 1'b0 : in_v_r);
  assign byte_nxt = (in_valid && !in_stall) ? in_text_byte : byte_r;

  always_comb begin
    push   = res;
    push.n = proc ? res.n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      pend_r  <= 1'b0;
      start_r <= '0;
      exp_r   <= 2'd0;
      dv_r    <= '0;
      seen_r  <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (proc) begin
        pend_r  <= pend_nxt;
        start_r <= start_nxt;
        exp_r   <= exp_nxt;
        dv_r    <= dv_nxt;
        seen_r  <= seen_nxt;
      end
    end
    byte_r <= byte_nxt;
  end

endmodule
